// ===== sv/nssgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nssgd_pkg;
  localparam int unsigned VocabDefault  = 1024;
  localparam int unsigned DimsDefault   = 64;
  localparam int unsigned MaxNegDefault = 4;
  localparam int unsigned SigEntries    = 256;
  localparam logic [1:0] OpTrain = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic               table_select;
    logic [9:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] weight_value;
    logic [9:0]         example_word;
    logic [9:0]         label_word;
    logic [15:0]        step_size;
    logic [9:0]         neg_word_0;
    logic [9:0]         neg_word_1;
    logic [9:0]         neg_word_2;
    logic [9:0]         neg_word_3;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic [2:0]         negatives_applied;
  } out_item_t;

  typedef logic [SigEntries-1:0][16:0] sig_rom_t;

  // Build the sigmoid table: the upper half is round(2^48 / (2^32 + e)) with
  // e = 2^32 * exp(-k/16) stepped by floored products, the lower half mirrors it
  function automatic sig_rom_t sig_rom_build();
    sig_rom_t    t;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [16:0] v;
    t = '0;
    e = 64'd1 << 32;
    for (int unsigned k = 0; k <= 128; k++) begin
      d   = (64'd1 << 32) + e;
      num = (64'd1 << 48) + (d >> 1);
      // Quotient bit by bit; it never exceeds 17 bits
      v = '0;
      for (int b = 16; b >= 0; b--) begin
        if ((64'(v) | (64'd1 << b)) * d <= num) v[b] = 1'b1;
      end
      if (k < 128) t[128 + k] = v;
      if (k > 0) t[128 - k] = 17'(17'd65536 - v);
      e = (e * 64'd4034748382) >> 32;
    end
    return t;
  endfunction

  localparam sig_rom_t SigRom = sig_rom_build();
endpackage
`default_nettype wire

// ===== sv/negative_sampling_sgd_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake                   Payload
// input    in_valid_i / in_ready_o     in_data_i   (nssgd_pkg::in_item_t)
// result   out_valid_o / out_ready_i   out_data_o  (nssgd_pkg::out_item_t)
// config   cfg_we_i                    cfg_wdata_i (negative_count)
// A write or read passes through S_RW and S_OUT before its result is given.
// For a train item, each pass (the positive, then each negative used) streams
// DIMS elements through the tables for the dot, then again for the update,
// and a last pass adds the buffer to the centre row.
// Reset clears control only; the tables and the gradient buffer are not
// cleared, the positive pass sets the buffer before it is read.
// A result waits in the output register; the next item enters once it is taken.
module negative_sampling_sgd_update #(
  parameter int unsigned VOCAB   = nssgd_pkg::VocabDefault,
  parameter int unsigned DIMS    = nssgd_pkg::DimsDefault,
  parameter int unsigned MAX_NEG = nssgd_pkg::MaxNegDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire nssgd_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output nssgd_pkg::out_item_t      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_wdata_i
);
  localparam int unsigned RW = (VOCAB > 1) ? $clog2(VOCAB) : 1;
  localparam int unsigned CW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int unsigned AW = RW + CW;
  localparam int unsigned CCW = $clog2(DIMS + 1);
  localparam logic [CCW-1:0] DimsC = CCW'(DIMS);

  localparam logic [2:0] S_IDLE = 3'd0, S_RW = 3'd1, S_DOT = 3'd2, S_SIG = 3'd3,
                         S_UPD = 3'd4, S_NEXT = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;

  logic signed [15:0] in_mem  [2**AW];
  logic signed [15:0] out_mem [2**AW];
  logic signed [23:0] grad_q  [2**CW];

  logic [2:0] state_q;
  logic [2:0] ncount_q;
  nssgd_pkg::in_item_t item_q;
  logic [CCW-1:0] cnt_q;       // issue counter
  logic           rvld_q;      // read data valid this cycle
  logic [CW-1:0]  rcol_q;      // column of read data
  logic [2:0]     pass_q;      // 0 positive, 1..4 negatives
  logic [RW-1:0]  orow_q;
  logic signed [47:0] dot_q;
  logic signed [17:0] gl_q;
  logic [2:0]     applied_q;
  logic signed [15:0] rin_q, rout_q;
  logic signed [23:0] rgrad_q;
  logic signed [15:0] rd_q;
  nssgd_pkg::out_item_t res_q;
  logic           ovld_q;

  logic [RW-1:0] ex_row;
  assign ex_row = item_q.example_word[RW-1:0];

  // Pick the word of a given pass
  function automatic logic [9:0] neg_word(input nssgd_pkg::in_item_t it,
                                          input logic [2:0] p);
    unique case (p)
      3'd1: return it.neg_word_0;
      3'd2: return it.neg_word_1;
      3'd3: return it.neg_word_2;
      default: return it.neg_word_3;
    endcase
  endfunction

  logic [2:0] nlim;
  assign nlim = (ncount_q > 3'(MAX_NEG)) ? 3'(MAX_NEG) : ncount_q;

  // Search the next usable negative after pass p
  logic [2:0] nxt_pass;
  logic       nxt_ok;
  always_comb begin
    logic [9:0] w;
    nxt_ok = 1'b0;
    nxt_pass = 3'd0;
    for (int k = 4; k >= 1; k--) begin
      w = neg_word(item_q, 3'(k));
      if (3'(k) > pass_q && 3'(k) <= nlim && w != item_q.label_word &&
          32'(w) < VOCAB) begin
        nxt_ok = 1'b1;
        nxt_pass = 3'(k);
      end
    end
  end

  logic [9:0] nxt_word;
  assign nxt_word = neg_word(item_q, nxt_pass);

  logic [CW-1:0] col_c;
  assign col_c = cnt_q[CW-1:0];

  assign in_ready_o  = (state_q == S_IDLE) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign out_data_o  = res_q;

  // Sigmoid lookup of the finished dot
  logic [7:0]  sidx;
  logic [16:0] sval;
  logic [16:0] gmag;
  logic [32:0] glp;
  always_comb begin
    if (dot_q < -(48'sd8 <<< 24)) sidx = 8'd0;
    else if (dot_q >= (48'sd8 <<< 24)) sidx = 8'd255;
    else sidx = 8'(48'(dot_q + (48'sd8 <<< 24)) >> 20);
    sval = nssgd_pkg::SigRom[sidx];
    gmag = (pass_q == 3'd0) ? 17'(17'd65536 - sval) : sval;
    glp  = 33'((34'(gmag) * 34'(item_q.step_size) + 34'd32768) >> 16);
  end

  // Update arithmetic on the registered read data
  logic signed [34:0] tprod, uprod;
  logic signed [18:0] term, upd;
  logic signed [24:0] gsum;
  logic signed [16:0] osum;
  logic signed [23:0] gnew;
  logic signed [15:0] onew;
  logic signed [24:0] isum;
  logic signed [15:0] inew;
  always_comb begin
    tprod = 35'(rout_q) * 35'(gl_q) + 35'sd32768;
    uprod = 35'(rin_q) * 35'(gl_q) + 35'sd32768;
    term  = 19'(tprod >>> 16);
    upd   = 19'(uprod >>> 16);
    gsum  = ((pass_q == 3'd0) ? 25'sd0 : 25'(rgrad_q)) + 25'(term);
    gnew  = (gsum > 25'sd8388607) ? 24'sd8388607 :
            (gsum < -25'sd8388608) ? -24'sd8388608 : 24'(gsum);
    osum  = 17'(19'(rout_q) + upd);
    if (19'(rout_q) + upd > 19'sd32767) onew = 16'sd32767;
    else if (19'(rout_q) + upd < -19'sd32768) onew = -16'sd32768;
    else onew = 16'(osum);
    isum  = 25'(rin_q) + 25'(rgrad_q);
    inew  = (isum > 25'sd32767) ? 16'sd32767 :
            (isum < -25'sd32768) ? -16'sd32768 : 16'(isum);
  end

  logic [AW-1:0] a_in, a_out, a_in_w, a_out_w, a_rw;
  assign a_in    = {ex_row, col_c};
  assign a_out   = {orow_q, col_c};
  assign a_in_w  = {ex_row, rcol_q};
  assign a_out_w = {orow_q, rcol_q};
  assign a_rw    = {item_q.row_index[RW-1:0], item_q.col_index[CW-1:0]};
  logic rw_ok;
  assign rw_ok = 32'(item_q.row_index) < VOCAB && 32'(item_q.col_index) < DIMS;

  // Table ports: read in DOT/UPD/FIN/RW; UPD and FIN write back in the cycle after the read, RW writes directly
  always_ff @(posedge clk_i) begin
    if (state_q == S_RW && rw_ok) begin
      if (item_q.operation == nssgd_pkg::OpWrite) begin
        if (item_q.table_select) out_mem[a_rw] <= item_q.weight_value;
        else in_mem[a_rw] <= item_q.weight_value;
      end
      rd_q <= item_q.table_select ? out_mem[a_rw] : in_mem[a_rw];
    end
    if ((state_q == S_DOT || state_q == S_UPD || state_q == S_FIN) && cnt_q < DimsC) begin
      rin_q   <= in_mem[a_in];
      rout_q  <= out_mem[a_out];
      rgrad_q <= grad_q[col_c];
    end
    if (state_q == S_UPD && rvld_q) begin
      out_mem[a_out_w] <= onew;
      grad_q[rcol_q]   <= gnew;
    end
    if (state_q == S_FIN && rvld_q) in_mem[a_in_w] <= inew;
  end

  // Control sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ncount_q <= 3'd4; ovld_q <= 1'b0; rvld_q <= 1'b0;
      cnt_q <= '0; pass_q <= '0; applied_q <= '0;
      item_q <= '0; orow_q <= '0; dot_q <= '0; gl_q <= '0; rcol_q <= '0;
      res_q <= '0;
    end else begin
      if (cfg_we_i) ncount_q <= cfg_wdata_i;
      if (ovld_q && out_ready_i) ovld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            item_q <= in_data_i; cnt_q <= '0; pass_q <= '0; applied_q <= '0;
            orow_q <= in_data_i.label_word[RW-1:0];
            if (in_data_i.operation == nssgd_pkg::OpWrite ||
                in_data_i.operation == nssgd_pkg::OpRead) state_q <= S_RW;
            else if (in_data_i.operation == nssgd_pkg::OpTrain &&
                     32'(in_data_i.example_word) < VOCAB &&
                     32'(in_data_i.label_word) < VOCAB) begin
              state_q <= S_DOT; dot_q <= '0;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_RW: state_q <= S_OUT;
        S_DOT: begin
          rvld_q <= (cnt_q < DimsC);
          if (cnt_q < DimsC) begin
            cnt_q <= cnt_q + 1'b1; rcol_q <= col_c;
          end
          if (rvld_q) dot_q <= dot_q + 48'(32'(rin_q) * 32'(rout_q));
          if (cnt_q == DimsC && !rvld_q) state_q <= S_SIG;
        end
        S_SIG: begin
          gl_q <= (pass_q == 3'd0) ? 18'(glp) : -18'(glp);
          cnt_q <= '0; state_q <= S_UPD;
        end
        S_UPD: begin
          rvld_q <= (cnt_q < DimsC);
          if (cnt_q < DimsC) begin
            cnt_q <= cnt_q + 1'b1; rcol_q <= col_c;
          end
          if (cnt_q == DimsC && !rvld_q) state_q <= S_NEXT;
        end
        S_NEXT: begin
          cnt_q <= '0;
          if (nxt_ok) begin
            pass_q <= nxt_pass; orow_q <= nxt_word[RW-1:0];
            applied_q <= applied_q + 1'b1; dot_q <= '0; state_q <= S_DOT;
          end else state_q <= S_FIN;
        end
        S_FIN: begin
          rvld_q <= (cnt_q < DimsC);
          if (cnt_q < DimsC) begin
            cnt_q <= cnt_q + 1'b1; rcol_q <= col_c;
          end
          if (cnt_q == DimsC && !rvld_q) state_q <= S_OUT;
        end
        S_OUT: begin
          res_q.read_value <= (item_q.operation == nssgd_pkg::OpRead && rw_ok) ?
                              rd_q : 16'sd0;
          res_q.negatives_applied <= applied_q;
          ovld_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
